/* rtl/tdd_pkg.sv */
// Shared types, codes and constants for the thruster direction detector.
package tdd_pkg;

   // Number of motors fitted to the vehicle (indexes 8 and up never enable)
   localparam int NUM_MOTORS = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTORS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_MS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRUST_MS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RP_RATE_LIMIT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_RATE_LIMIT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_SQ_LIMIT = 3'd7;

   // Event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_OK       = 3'd1;
   localparam logic [2:0] EV_REVERSED = 3'd2;
   localparam logic [2:0] EV_RETRY    = 3'd3;
   localparam logic [2:0] EV_FAILED   = 3'd4;

   // Pulse widths in microseconds
   localparam logic [10:0] PULSE_IDLE_US = 11'd1500;
   localparam logic [10:0] PULSE_UP_US   = 11'd1800;
   localparam logic [10:0] PULSE_DOWN_US = 11'd1200;

   typedef enum logic [2:0] {
      PH_STOPPED   = 3'd0,
      PH_SETTLING  = 3'd1,
      PH_THRUSTING = 3'd2,
      PH_DETECTING = 3'd3,
      PH_DONE      = 3'd4
   } phase_type;

   // Configuration registers
   typedef struct packed {
      logic [7:0]  motor_enable_mask;
      logic [47:0] expected_factors;
      logic [15:0] settle_ms;
      logic [15:0] thrust_ms;
      logic [14:0] tilt_limit_cd;
      logic [14:0] roll_pitch_rate_limit;
      logic [14:0] yaw_rate_limit;
      logic [31:0] still_rate_sq_limit;
   } cfg_type;

   // One input word
   typedef struct packed {
      logic [31:0] now_ms;
      logic        start_request;
      logic        is_armed;
      logic [15:0] roll_cd;
      logic [15:0] pitch_cd;
      logic [15:0] rate_x;
      logic [15:0] rate_y;
      logic [15:0] rate_z;
      logic        output_accepted;
   } req_type;

   // One result word
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  motor_under_test;
      logic        neutral_all;
      logic        test_active;
      logic [10:0] test_pulse_us;
      logic [2:0]  event_code;
      logic [7:0]  reversed_mask;
      logic        spool_down;
      logic        disarm_request;
   } rsp_type;

   // Sequencer state carried from one word to the next
   typedef struct packed {
      phase_type   phase;
      logic [31:0] phase_start_ms;
      logic [3:0]  motor_index;
      logic        push_down;
      logic [7:0]  reversed_bits;
      logic        pulse_pending;
   } state_type;

endpackage

/* rtl/thruster_direction_detect.sv */
// Top level of the thruster direction detector: word registers, state and handshakes.
//
//   channel   ports         direction   transfer
//   request   req_*         in          req_valid & req_ready, one tick word
//   response  rsp_*         out         rsp_valid & rsp_ready, one result word
//   config    csr_*         in          csr_we, single cycle write, no read-back
//
// Throughput is one word per cycle while the response is not stalled; a word
// passes the input register, then the sequencer logic into the result register.
// The sequencer state advances when a word moves into the result register,
// so the next word always sees the state left by the one before it.
// A stalled response holds the result register; the input register keeps
// accepting until it too holds a word. Reset is synchronous and active high
// and returns the sequencer to the stopped phase with default registers.
module thruster_direction_detect
   import tdd_pkg::*;
#(
   parameter int MOTOR_COUNT = NUM_MOTORS
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_now_ms,
   input  logic                   req_start_request,
   input  logic                   req_is_armed,
   input  logic signed [15:0]     req_roll_cd,
   input  logic signed [15:0]     req_pitch_cd,
   input  logic signed [15:0]     req_rate_x,
   input  logic signed [15:0]     req_rate_y,
   input  logic signed [15:0]     req_rate_z,
   input  logic                   req_output_accepted,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_phase,
   output logic [3:0]             rsp_motor_under_test,
   output logic                   rsp_neutral_all,
   output logic                   rsp_test_active,
   output logic [10:0]            rsp_test_pulse_us,
   output logic [2:0]             rsp_event_code,
   output logic [7:0]             rsp_reversed_mask,
   output logic                   rsp_spool_down,
   output logic                   rsp_disarm_request,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg;
   req_type   in_ff;
   logic      in_valid_ff;
   rsp_type   out_ff;
   rsp_type   out_in;
   logic      out_valid_ff;
   state_type state_ff;
   state_type state_in;
   logic      advance;

   tdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tdd_step #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_step (
      .item (in_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (out_in)
   );

   // Word moves forward when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || advance);

   // Control: valid flags and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.phase          <= PH_STOPPED;
         state_ff.phase_start_ms <= 32'd0;
         state_ff.motor_index    <= 4'd0;
         state_ff.push_down      <= 1'b0;
         state_ff.reversed_bits  <= 8'd0;
         state_ff.pulse_pending  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.now_ms          <= req_now_ms;
         in_ff.start_request   <= req_start_request;
         in_ff.is_armed        <= req_is_armed;
         in_ff.roll_cd         <= req_roll_cd;
         in_ff.pitch_cd        <= req_pitch_cd;
         in_ff.rate_x          <= req_rate_x;
         in_ff.rate_y          <= req_rate_y;
         in_ff.rate_z          <= req_rate_z;
         in_ff.output_accepted <= req_output_accepted;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // Result ports
   assign rsp_valid            = out_valid_ff;
   assign rsp_phase            = out_ff.phase;
   assign rsp_motor_under_test = out_ff.motor_under_test;
   assign rsp_neutral_all      = out_ff.neutral_all;
   assign rsp_test_active      = out_ff.test_active;
   assign rsp_test_pulse_us    = out_ff.test_pulse_us;
   assign rsp_event_code       = out_ff.event_code;
   assign rsp_reversed_mask    = out_ff.reversed_mask;
   assign rsp_spool_down       = out_ff.spool_down;
   assign rsp_disarm_request   = out_ff.disarm_request;

endmodule

/* rtl/tdd_csr.sv */
// Configuration register file for the thruster direction detector.
module tdd_csr
   import tdd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign cfg = cfg_ff;

   // Register writes, each truncated to the register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_enable_mask     <= 8'd15;
         cfg_ff.expected_factors      <= 48'd0;
         cfg_ff.settle_ms             <= 16'd500;
         cfg_ff.thrust_ms             <= 16'd500;
         cfg_ff.tilt_limit_cd         <= 15'd1000;
         cfg_ff.roll_pitch_rate_limit <= 15'd1638;
         cfg_ff.yaw_rate_limit        <= 15'd2048;
         cfg_ff.still_rate_sq_limit   <= 32'd167772;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MOTOR_ENABLE:   cfg_ff.motor_enable_mask     <= csr_wdata[7:0];
            CSR_FACTORS:        cfg_ff.expected_factors      <= csr_wdata[47:0];
            CSR_SETTLE_MS:      cfg_ff.settle_ms             <= csr_wdata[15:0];
            CSR_THRUST_MS:      cfg_ff.thrust_ms             <= csr_wdata[15:0];
            CSR_TILT_LIMIT:     cfg_ff.tilt_limit_cd         <= csr_wdata[14:0];
            CSR_RP_RATE_LIMIT:  cfg_ff.roll_pitch_rate_limit <= csr_wdata[14:0];
            CSR_YAW_RATE_LIMIT: cfg_ff.yaw_rate_limit        <= csr_wdata[14:0];
            CSR_STILL_SQ_LIMIT: cfg_ff.still_rate_sq_limit   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/tdd_step.sv */
// Per-word phase sequencer logic: next state and result from one input word.
module tdd_step
   import tdd_pkg::*;
#(
   parameter int MOTOR_COUNT = NUM_MOTORS
)
(
   input  req_type   item,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   res
);

   logic               [15:0] roll_mag;
   logic               [15:0] pitch_mag;
   logic signed        [15:0] rx;
   logic signed        [15:0] ry;
   logic signed        [15:0] rz;
   logic signed        [31:0] sq_x;
   logic signed        [31:0] sq_y;
   logic signed        [31:0] sq_z;
   logic               [31:0] sq_sum;
   logic                      disturbed;
   logic               [31:0] settle_start;
   logic               [31:0] settle_elapsed;
   logic               [31:0] thrust_elapsed;
   logic signed        [16:0] rx_ext;
   logic signed        [16:0] ry_ext;
   logic signed        [16:0] rz_ext;
   logic signed        [16:0] rp_lim;
   logic signed        [16:0] yaw_lim;
   logic               [1:0]  cls_x;
   logic               [1:0]  cls_y;
   logic               [1:0]  cls_z;
   logic               [1:0]  c0;
   logic               [1:0]  c1;
   logic               [1:0]  c2;
   logic               [5:0]  fac_sel;
   logic               [5:0]  fac;
   logic                      match_ok;
   logic                      match_rev;
   logic               [3:0]  motor_next;
   logic                      next_enabled;
   logic               [7:0]  rev_bit;
   phase_type                 ph_now;

   // Attitude magnitudes (unsigned, so the most negative value fits)
   assign roll_mag  = item.roll_cd[15] ? 16'(~item.roll_cd + 16'd1) : item.roll_cd;
   assign pitch_mag = item.pitch_cd[15] ? 16'(~item.pitch_cd + 16'd1) : item.pitch_cd;

   // Sum of squared rates, at most three times 2^30
   assign rx     = $signed(item.rate_x);
   assign ry     = $signed(item.rate_y);
   assign rz     = $signed(item.rate_z);
   assign sq_x   = rx * rx;
   assign sq_y   = ry * ry;
   assign sq_z   = rz * rz;
   assign sq_sum = 32'($unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z));

   // Level and still check restarts the settle timer
   assign disturbed = (roll_mag > {1'b0, cfg.tilt_limit_cd}) ||
                      (pitch_mag > {1'b0, cfg.tilt_limit_cd}) ||
                      (sq_sum > cfg.still_rate_sq_limit);
   assign settle_start   = disturbed ? item.now_ms : cur.phase_start_ms;
   assign settle_elapsed = item.now_ms - settle_start;
   assign thrust_elapsed = item.now_ms - cur.phase_start_ms;

   // Rate classes: +1 above limit, -1 below minus limit, else 0
   assign rx_ext  = {rx[15], rx};
   assign ry_ext  = {ry[15], ry};
   assign rz_ext  = {rz[15], rz};
   assign rp_lim  = $signed({2'b00, cfg.roll_pitch_rate_limit});
   assign yaw_lim = $signed({2'b00, cfg.yaw_rate_limit});
   assign cls_x = (rx_ext > rp_lim) ? 2'b01 : ((rx_ext < -rp_lim) ? 2'b11 : 2'b00);
   assign cls_y = (ry_ext > rp_lim) ? 2'b01 : ((ry_ext < -rp_lim) ? 2'b11 : 2'b00);
   assign cls_z = (rz_ext > yaw_lim) ? 2'b01 : ((rz_ext < -yaw_lim) ? 2'b11 : 2'b00);

   // A down push flips the observed response
   assign c0 = cur.push_down ? 2'(2'd0 - cls_x) : cls_x;
   assign c1 = cur.push_down ? 2'(2'd0 - cls_y) : cls_y;
   assign c2 = cur.push_down ? 2'(2'd0 - cls_z) : cls_z;

   // Expected factors of the motor under test; zero beyond motor 7
   assign fac_sel = 6'(cur.motor_index[2:0]) * 6'd6;
   assign fac     = cur.motor_index[3] ? 6'd0 : cfg.expected_factors[fac_sel +: 6];

   // A factor code of -2 never equals a class, so it falls to a bad read
   assign match_ok  = (c0 == fac[1:0]) && (c1 == fac[3:2]) && (c2 == fac[5:4]);
   assign match_rev = (2'(2'd0 - c0) == fac[1:0]) && (2'(2'd0 - c1) == fac[3:2]) &&
                      (2'(2'd0 - c2) == fac[5:4]);

   // Next motor and whether it is fitted and enabled
   assign motor_next   = 4'(cur.motor_index + 4'd1);
   assign next_enabled = (32'(motor_next) < MOTOR_COUNT) && !motor_next[3] &&
                         cfg.motor_enable_mask[motor_next[2:0]];
   assign rev_bit      = cur.motor_index[3] ? 8'd0 : (8'd1 << cur.motor_index[2:0]);

   // Phase sequencer
   always_comb begin
      nxt               = cur;
      nxt.pulse_pending = 1'b0;
      res               = '0;
      ph_now            = item.start_request ? PH_STOPPED : cur.phase;
      nxt.phase         = ph_now;

      if (!item.is_armed) begin
         res.spool_down  = 1'b1;
         res.neutral_all = 1'b1;
         nxt.phase       = PH_DONE;
      end else begin
         case (ph_now)
            PH_STOPPED: begin
               nxt.push_down      = 1'b0;
               nxt.motor_index    = 4'd0;
               nxt.phase_start_ms = item.now_ms;
               nxt.phase          = PH_SETTLING;
            end
            PH_SETTLING: begin
               res.neutral_all    = 1'b1;
               nxt.phase_start_ms = settle_start;
               if (settle_elapsed > {16'd0, cfg.settle_ms}) begin
                  nxt.phase          = PH_THRUSTING;
                  nxt.phase_start_ms = item.now_ms;
               end
            end
            PH_THRUSTING: begin
               if (thrust_elapsed < {16'd0, cfg.thrust_ms}) begin
                  if (cur.pulse_pending && !item.output_accepted) begin
                     nxt.phase = PH_DONE;
                  end else begin
                     res.test_active   = 1'b1;
                     nxt.pulse_pending = 1'b1;
                  end
               end else begin
                  nxt.phase = PH_DETECTING;
               end
            end
            PH_DETECTING: begin
               if (match_ok || match_rev) begin
                  res.event_code = match_ok ? EV_OK : EV_REVERSED;
                  if (!match_ok) begin
                     nxt.reversed_bits = cur.reversed_bits | rev_bit;
                  end
                  nxt.motor_index = motor_next;
                  nxt.push_down   = 1'b0;
                  nxt.phase       = next_enabled ? PH_SETTLING : PH_DONE;
               end else if (cur.push_down) begin
                  res.event_code = EV_FAILED;
                  nxt.phase      = PH_DONE;
               end else begin
                  res.event_code = EV_RETRY;
                  nxt.push_down  = 1'b1;
                  nxt.phase      = PH_SETTLING;
               end
            end
            PH_DONE: begin
               res.disarm_request = 1'b1;
            end
            default: begin
               nxt.phase = PH_DONE;
            end
         endcase
      end

      // Result fields that follow the updated state
      res.phase            = nxt.phase;
      res.motor_under_test = nxt.motor_index;
      res.reversed_mask    = nxt.reversed_bits;
      if (res.test_active) begin
         res.test_pulse_us = nxt.push_down ? PULSE_DOWN_US : PULSE_UP_US;
      end else begin
         res.test_pulse_us = PULSE_IDLE_US;
      end
   end

endmodule
